@@ src/assert_macros.svh @@
// Assertion macros for the depthwise convolution block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, c)
`define ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

@@ src/dwc_pkg.sv @@
package dwc_pkg;
    localparam int DEF_MAX_CHANNELS = 256;
    localparam int DEF_MAX_TAPS = 64;
    localparam logic [1:0] KIND_PARAM = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_TAP = 2'd2;
    localparam logic [1:0] REG_IN_ZP = 2'd0;
    localparam logic [1:0] REG_OUT_ZP = 2'd1;
    localparam logic [1:0] REG_ACT_MIN = 2'd2;
    localparam logic [1:0] REG_ACT_MAX = 2'd3;
    localparam logic signed [7:0] INT8_MIN = -8'sd128;
    localparam logic signed [7:0] INT8_MAX = 8'sd127;

    typedef struct packed {
        logic [7:0]         channel;
        logic signed [31:0] bias;
        logic [30:0]        multiplier;
        logic signed [5:0]  shift;
        logic signed [31:0] acc;
    } rq_req_t;
endpackage

@@ src/dwc_mac.sv @@
module dwc_mac
    import dwc_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic [1:0]         kind,
    input  logic [7:0]         channel,
    input  logic [5:0]         tap,
    input  logic signed [7:0]  activation,
    input  logic               in_bounds,
    input  logic               first_tap,
    input  logic               last_tap,
    input  logic signed [7:0]  weight,
    input  logic signed [31:0] bias,
    input  logic [30:0]        multiplier,
    input  logic signed [5:0]  shift,
    input  logic signed [7:0]  in_zp,
    output logic               s1_busy,
    output logic               rq_valid,
    output rq_req_t            rq_req
);
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    logic signed [7:0]  wmem [MAX_TAPS << CW];
    logic signed [31:0] bmem [MAX_CHANNELS];
    logic [30:0]        mmem [MAX_CHANNELS];
    logic signed [5:0]  smem [MAX_CHANNELS];
    logic [31:0]        amem [MAX_CHANNELS];

    logic        ch_ok, tap_ok;
    logic [CW-1:0] ch_idx;
    logic [TW-1:0] tap_idx;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_ch_reg;
    logic [7:0]    s1_chfull_reg;
    logic          s1_tapok_reg, s1_inb_reg, s1_first_reg, s1_last_reg;
    logic signed [8:0] s1_diff_reg;
    logic signed [7:0] s1_w_reg;
    logic [31:0]   s1_acc_rd_reg;
    logic signed [31:0] s1_bias_reg;
    logic [30:0]   s1_mult_reg;
    logic signed [5:0] s1_shift_reg;

    logic          s2_valid_reg;
    logic [CW-1:0] s2_ch_reg;
    logic [31:0]   s2_acc_reg;

    logic [31:0] acc_old, acc_new;
    logic signed [16:0] prod;

    assign ch_ok = ({3'b0, channel} < 11'(MAX_CHANNELS));
    assign tap_ok = ({3'b0, tap} < 9'(MAX_TAPS));
    assign ch_idx = CW'(channel);
    assign tap_idx = TW'(tap);
    assign s1_busy = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (in_fire && ch_ok && kind == KIND_PARAM) begin
            bmem[ch_idx] <= bias;
            mmem[ch_idx] <= multiplier;
            smem[ch_idx] <= shift;
        end
        if (in_fire && ch_ok && tap_ok && kind == KIND_WEIGHT) begin
            wmem[{tap_idx, ch_idx}] <= weight;
        end
        s1_w_reg <= wmem[{tap_idx, ch_idx}];
        s1_acc_rd_reg <= amem[ch_idx];
        s1_bias_reg <= bmem[ch_idx];
        s1_mult_reg <= mmem[ch_idx];
        s1_shift_reg <= smem[ch_idx];
        s1_ch_reg <= ch_idx;
        s1_chfull_reg <= channel;
        s1_tapok_reg <= tap_ok;
        s1_inb_reg <= in_bounds;
        s1_first_reg <= first_tap;
        s1_last_reg <= last_tap;
        s1_diff_reg <= 9'(activation) - 9'(in_zp);
        if (s1_valid_reg) begin
            amem[s1_ch_reg] <= acc_new;
        end
        s2_ch_reg <= s1_ch_reg;
        s2_acc_reg <= acc_new;
        rq_req.channel <= s1_chfull_reg;
        rq_req.bias <= s1_bias_reg;
        rq_req.multiplier <= s1_mult_reg;
        rq_req.shift <= s1_shift_reg;
        rq_req.acc <= acc_new;
    end

    always_comb begin
        if (s1_first_reg) begin
            acc_old = '0;
        end else if (s2_valid_reg && s2_ch_reg == s1_ch_reg) begin
            acc_old = s2_acc_reg;
        end else begin
            acc_old = s1_acc_rd_reg;
        end
        prod = s1_diff_reg * (s1_tapok_reg ? s1_w_reg : 8'sd0);
        acc_new = acc_old + (s1_inb_reg ? 32'(prod) : 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            rq_valid <= 1'b0;
        end else begin
            s1_valid_reg <= in_fire && ch_ok && kind == KIND_TAP;
            s2_valid_reg <= s1_valid_reg;
            rq_valid <= s1_valid_reg && s1_last_reg;
        end
    end
endmodule

@@ src/dwc_requant.sv @@
module dwc_requant
    import dwc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rq_valid,
    input  rq_req_t           rq_req,
    input  logic signed [7:0] out_zp,
    input  logic signed [7:0] act_min,
    input  logic signed [7:0] act_max,
    output logic [2:0]        busy,
    output logic              res_valid,
    output logic [7:0]        res_channel,
    output logic signed [7:0] res_value
);
    logic signed [31:0] sum, y;
    logic [4:0] lsh;
    logic [5:0] rsh;

    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic [7:0] a_ch_reg, b_ch_reg, c_ch_reg;
    logic signed [31:0] a_y_reg;
    logic signed [31:0] a_m_reg;
    logic [5:0] a_r_reg, b_r_reg;
    logic signed [63:0] b_ab_reg;
    logic signed [31:0] c_hi_reg;
    logic [5:0] c_r_reg;

    logic signed [63:0] nudged, ab;
    logic signed [31:0] hi;
    logic signed [32:0] q, v, r;
    logic [31:0] mask, rem, thr;

    assign sum = rq_req.acc + rq_req.bias;
    assign lsh = (rq_req.shift > 0) ? rq_req.shift[4:0] : 5'd0;
    assign rsh = (rq_req.shift > 0) ? 6'd0 : 6'(-rq_req.shift);
    assign y = sum << lsh;
    assign ab = a_y_reg * a_m_reg;
    assign busy = {2'd0, a_valid_reg} + {2'd0, b_valid_reg} + {2'd0, c_valid_reg}
        + {2'd0, res_valid};

    always_comb begin
        nudged = b_ab_reg + ((b_ab_reg >= 0) ? 64'sd1073741824 : -64'sd1073741823);
        if (nudged < 0) begin
            hi = 32'((nudged + 64'sd2147483647) >>> 31);
        end else begin
            hi = 32'(nudged >>> 31);
        end
        mask = (c_r_reg >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << c_r_reg[4:0]) - 32'd1);
        rem = c_hi_reg & mask;
        thr = (mask >> 1) + {31'd0, c_hi_reg[31]};
        if (c_r_reg >= 6'd32) begin
            q = {33{c_hi_reg[31]}};
        end else begin
            q = 33'(c_hi_reg) >>> c_r_reg[4:0];
        end
        if (c_r_reg != 6'd0 && rem > thr) begin
            q = q + 33'sd1;
        end
        v = q + 33'(out_zp);
        r = v;
        if (r < 33'(act_min)) r = 33'(act_min);
        if (r > 33'(act_max)) r = 33'(act_max);
        if (r < 33'(INT8_MIN)) r = 33'(INT8_MIN);
        if (r > 33'(INT8_MAX)) r = 33'(INT8_MAX);
    end

    always_ff @(posedge aclk) begin
        a_ch_reg <= rq_req.channel;
        a_y_reg <= y;
        a_m_reg <= {1'b0, rq_req.multiplier};
        a_r_reg <= rsh;
        b_ch_reg <= a_ch_reg;
        b_ab_reg <= ab;
        b_r_reg <= a_r_reg;
        c_ch_reg <= b_ch_reg;
        c_hi_reg <= hi;
        c_r_reg <= b_r_reg;
        res_channel <= c_ch_reg;
        res_value <= r[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            res_valid <= 1'b0;
        end else begin
            a_valid_reg <= rq_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            res_valid <= c_valid_reg;
        end
    end
endmodule

@@ src/dwc_outq.sv @@
module dwc_outq
    import dwc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [7:0]        wr_channel,
    input  logic signed [7:0] wr_value,
    output logic [3:0]        count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_channel,
    output logic signed [7:0] m_result
);
    logic [15:0] mem [8];
    logic [2:0] wp_reg, rp_reg;
    logic [3:0] cnt_reg;
    logic rd;

    assign rd = m_valid && m_ready;
    assign m_valid = (cnt_reg != 4'd0);
    assign {m_out_channel, m_result} = mem[rp_reg];
    assign count = cnt_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= {wr_channel, wr_value};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 3'd1;
            if (rd) rp_reg <= rp_reg + 3'd1;
            cnt_reg <= cnt_reg + {3'd0, wr_en} - {3'd0, rd};
        end
    end
endmodule

@@ src/int8_depthwise_conv_mac_requant_top.sv @@
// Per-channel int8 depthwise convolution with requantization.
// Input channel s_*: kind 0 loads a channel's bias, multiplier and shift,
// kind 1 loads one filter weight, kind 2 brings one activation tap.
// A kind 2 item with last_tap set yields one item on m_* (channel, value).
// One item is accepted per cycle while s_ready is high; the accumulator
// memory is read at the accepting edge and written back at the next, with
// forwarding between taps. A last tap's result passes through the MAC stage
// and the four-stage requantizer with its 32x32 multiply.
// The output queue holds eight items; s_ready drops while the queue and the
// six pipeline stages together hold eight items, so a stalled receiver
// stops intake without loss.
// Reset clears the control state and the registers to their defaults;
// tables are undefined until loaded and need no clearing pass.
// Configuration: cfg_we, cfg_index and cfg_data write a register at once.
`include "assert_macros.svh"
module int8_depthwise_conv_mac_requant_top
    import dwc_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [7:0]         s_channel,
    input  logic [5:0]         s_tap,
    input  logic signed [7:0]  s_activation,
    input  logic               s_in_bounds,
    input  logic               s_first_tap,
    input  logic               s_last_tap,
    input  logic signed [7:0]  s_weight,
    input  logic signed [31:0] s_bias,
    input  logic [30:0]        s_multiplier,
    input  logic signed [5:0]  s_shift,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_channel,
    output logic signed [7:0]  m_result
);
    logic signed [7:0] in_zp_reg, out_zp_reg, act_min_reg, act_max_reg;
    logic in_fire, rq_valid, res_valid, s1_busy;
    rq_req_t rq_req;
    logic [7:0] res_channel;
    logic signed [7:0] res_value;
    logic [3:0] count;
    logic [2:0] rq_busy;
    logic [3:0] pending;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_zp_reg <= '0;
            out_zp_reg <= '0;
            act_min_reg <= INT8_MIN;
            act_max_reg <= INT8_MAX;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IN_ZP:   in_zp_reg <= cfg_data;
                REG_OUT_ZP:  out_zp_reg <= cfg_data;
                REG_ACT_MIN: act_min_reg <= cfg_data;
                REG_ACT_MAX: act_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Results still in flight plus those queued must fit in the queue.
    assign pending = count + {3'd0, rq_valid} + {3'd0, s1_busy} + {1'b0, rq_busy};
    assign s_ready = (pending < 4'd8);
    assign in_fire = s_valid && s_ready;

    dwc_mac #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_TAPS(MAX_TAPS)) u_mac (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .kind(s_kind),
        .channel(s_channel), .tap(s_tap), .activation(s_activation),
        .in_bounds(s_in_bounds), .first_tap(s_first_tap), .last_tap(s_last_tap),
        .weight(s_weight), .bias(s_bias), .multiplier(s_multiplier),
        .shift(s_shift), .in_zp(in_zp_reg), .s1_busy(s1_busy),
        .rq_valid(rq_valid), .rq_req(rq_req)
    );

    dwc_requant u_rq (
        .aclk(aclk), .aresetn(aresetn), .rq_valid(rq_valid), .rq_req(rq_req),
        .out_zp(out_zp_reg), .act_min(act_min_reg), .act_max(act_max_reg),
        .busy(rq_busy), .res_valid(res_valid), .res_channel(res_channel),
        .res_value(res_value)
    );

    dwc_outq u_q (
        .aclk(aclk), .aresetn(aresetn), .wr_en(res_valid), .wr_channel(res_channel),
        .wr_value(res_value), .count(count), .m_valid(m_valid), .m_ready(m_ready),
        .m_out_channel(m_out_channel), .m_result(m_result)
    );

    `ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, res_valid, count < 4'd8)
    `ASSERT_NEXT(a_rq_follows, aclk, aresetn, rq_valid, rq_busy != 3'd0)
    `ASSERT_IMPLIES(a_ready_room, aclk, aresetn, s_ready, count < 4'd8)
endmodule

@@ verif/int8_depthwise_conv_mac_requant_checker.sv @@
`timescale 1ns / 1ps

module int8_depthwise_conv_mac_requant_checker
    import dwc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [7:0]         s_channel,
    input  logic [5:0]         s_tap,
    input  logic signed [7:0]  s_activation,
    input  logic               s_in_bounds,
    input  logic               s_first_tap,
    input  logic               s_last_tap,
    input  logic signed [7:0]  s_weight,
    input  logic signed [31:0] s_bias,
    input  logic [30:0]        s_multiplier,
    input  logic signed [5:0]  s_shift,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_out_channel,
    input  logic signed [7:0]  m_result,
    output int                 mismatches,
    output int                 outstanding
);
    typedef struct {
        logic [7:0]        channel;
        logic signed [7:0] value;
    } conv_out_t;

    logic signed [7:0]  in_zp, out_zp, clamp_lo, clamp_hi;
    logic signed [7:0]  filter_mem [0:DEF_MAX_TAPS*DEF_MAX_CHANNELS-1];
    logic signed [31:0] bias_mem [0:DEF_MAX_CHANNELS-1];
    logic [30:0]        mult_mem [0:DEF_MAX_CHANNELS-1];
    logic signed [5:0]  shift_mem [0:DEF_MAX_CHANNELS-1];
    logic [31:0]        acc_mem [0:DEF_MAX_CHANNELS-1];
    conv_out_t          pending_outputs [$];

    assign outstanding = pending_outputs.size();

    initial mismatches = 0;

    task automatic report(input string what);
        $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic signed [7:0] requantise(input logic [31:0] sum,
            input logic [30:0] mult, input logic signed [5:0] sh);
        int      s;
        int      right;
        bit [31:0] y;
        longint  prod, nudge, hm, mask, rem, thr, q, r;
        s = sh;
        right = (s > 0) ? 0 : -s;
        y = (s > 0) ? (sum << s) : sum;
        prod = longint'(int'(signed'(y))) * longint'({33'd0, mult});
        nudge = (prod >= 0) ? (64'sd1 <<< 30) : (64'sd1 - (64'sd1 <<< 30));
        hm = (prod + nudge) / 64'sd2147483648;
        if (right == 0) begin
            q = hm;
        end else begin
            mask = (64'sd1 <<< right) - 1;
            rem = hm & mask;
            thr = (mask >>> 1) + ((hm < 0) ? 1 : 0);
            q = (hm >>> right) + ((rem > thr) ? 1 : 0);
        end
        r = q + longint'(out_zp);
        if (r < clamp_lo) r = clamp_lo;
        if (r > clamp_hi) r = clamp_hi;
        if (r < -128) r = -128;
        if (r > 127) r = 127;
        return r[7:0];
    endfunction

    always @(posedge aclk) begin
        conv_out_t exp_out;
        int        idx;
        if (!aresetn) begin
            in_zp <= 8'sd0;
            out_zp <= 8'sd0;
            clamp_lo <= INT8_MIN;
            clamp_hi <= INT8_MAX;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_IN_ZP:   in_zp <= cfg_data;
                    REG_OUT_ZP:  out_zp <= cfg_data;
                    REG_ACT_MIN: clamp_lo <= cfg_data;
                    REG_ACT_MAX: clamp_hi <= cfg_data;
                endcase
            end
            if (s_valid && s_ready) begin
                idx = s_tap * DEF_MAX_CHANNELS + s_channel;
                case (s_kind)
                    KIND_PARAM: begin
                        bias_mem[s_channel] = s_bias;
                        mult_mem[s_channel] = s_multiplier;
                        shift_mem[s_channel] = s_shift;
                    end
                    KIND_WEIGHT: filter_mem[idx] = s_weight;
                    KIND_TAP: begin
                        if (s_first_tap) acc_mem[s_channel] = 32'd0;
                        if (s_in_bounds)
                            acc_mem[s_channel] = acc_mem[s_channel]
                                + 32'((int'(s_activation) - int'(in_zp))
                                * int'(filter_mem[idx]));
                        if (s_last_tap) begin
                            exp_out.channel = s_channel;
                            exp_out.value = requantise(acc_mem[s_channel]
                                + bias_mem[s_channel], mult_mem[s_channel],
                                shift_mem[s_channel]);
                            pending_outputs.push_back(exp_out);
                        end
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_outputs.size() == 0) begin
                    report($sformatf("unexpected item: channel %0d value %0d",
                        m_out_channel, m_result));
                end else begin
                    exp_out = pending_outputs.pop_front();
                    if (m_out_channel !== exp_out.channel)
                        report($sformatf("channel %0d, expected %0d",
                            m_out_channel, exp_out.channel));
                    if (m_result !== exp_out.value)
                        report($sformatf("channel %0d value %0d, expected %0d",
                            exp_out.channel, m_result, exp_out.value));
                end
            end
        end
    end
endmodule

@@ verif/int8_depthwise_conv_mac_requant_top_tb.sv @@
`timescale 1ns / 1ps

module int8_depthwise_conv_mac_requant_top_tb;
    import dwc_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE = 10;

    typedef struct {
        logic [1:0]         kind;
        logic [7:0]         channel;
        logic [5:0]         tap;
        logic signed [7:0]  activation;
        logic               in_bounds;
        logic               first_tap;
        logic               last_tap;
        logic signed [7:0]  weight;
        logic signed [31:0] bias;
        logic [30:0]        multiplier;
        logic signed [5:0]  shift;
    } dw_item_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [7:0]         s_channel;
    logic [5:0]         s_tap;
    logic signed [7:0]  s_activation;
    logic               s_in_bounds;
    logic               s_first_tap;
    logic               s_last_tap;
    logic signed [7:0]  s_weight;
    logic signed [31:0] s_bias;
    logic [30:0]        s_multiplier;
    logic signed [5:0]  s_shift;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_out_channel;
    logic signed [7:0]  m_result;
    int                 mismatches;
    int                 outstanding;
    int                 cycles = 0;
    bit                 no_idle;
    bit                 started [0:DEF_MAX_CHANNELS-1];
    logic [7:0]         pool [0:POOL_SIZE-1];

    int8_depthwise_conv_mac_requant_top dut (.*);

    int8_depthwise_conv_mac_requant_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);

    function automatic dw_item_t noise_item();
        dw_item_t it;
        it.kind = 2'($urandom);
        it.channel = 8'($urandom);
        it.tap = 6'($urandom);
        it.activation = 8'($urandom);
        it.in_bounds = 1'($urandom);
        it.first_tap = 1'($urandom);
        it.last_tap = 1'($urandom);
        it.weight = 8'($urandom);
        it.bias = $urandom;
        it.multiplier = 31'($urandom);
        it.shift = 6'($urandom);
        return it;
    endfunction

    task automatic send_item(input dw_item_t it);
        if (!no_idle && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_channel <= it.channel;
        s_tap <= it.tap;
        s_activation <= it.activation;
        s_in_bounds <= it.in_bounds;
        s_first_tap <= it.first_tap;
        s_last_tap <= it.last_tap;
        s_weight <= it.weight;
        s_bias <= it.bias;
        s_multiplier <= it.multiplier;
        s_shift <= it.shift;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (it.kind == KIND_TAP) begin
            if (it.first_tap) started[it.channel] = 1'b1;
        end
    endtask

    task automatic load_params(input logic [7:0] ch, input logic signed [31:0] b,
            input logic [30:0] m, input logic signed [5:0] sh);
        dw_item_t it;
        it = noise_item();
        it.kind = KIND_PARAM;
        it.channel = ch;
        it.bias = b;
        it.multiplier = m;
        it.shift = sh;
        send_item(it);
    endtask

    task automatic load_weight(input logic [7:0] ch, input logic [5:0] tp,
            input logic signed [7:0] w);
        dw_item_t it;
        it = noise_item();
        it.kind = KIND_WEIGHT;
        it.channel = ch;
        it.tap = tp;
        it.weight = w;
        send_item(it);
    endtask

    task automatic send_tap(input logic [7:0] ch, input logic [5:0] tp,
            input logic signed [7:0] a, input bit inb, input bit fst, input bit lst);
        dw_item_t it;
        it = noise_item();
        it.kind = KIND_TAP;
        it.channel = ch;
        it.tap = tp;
        it.activation = a;
        it.in_bounds = inb;
        it.first_tap = fst;
        it.last_tap = lst;
        send_item(it);
    endtask

    task automatic random_params(input logic [7:0] ch);
        logic signed [5:0] sh;
        sh = ($urandom_range(9) < 7) ? 6'(-$urandom_range(14)) : 6'($urandom);
        load_params(ch, ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(4000)) - 2000,
            31'($urandom) | 31'h40000000 >> $urandom_range(2), sh);
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic set_config(input logic signed [7:0] izp, input logic signed [7:0] ozp,
            input logic signed [7:0] lo, input logic signed [7:0] hi);
        quiesce();
        cfg_we <= 1'b1;
        cfg_index <= REG_IN_ZP;
        cfg_data <= izp;
        @(negedge aclk);
        cfg_index <= REG_OUT_ZP;
        cfg_data <= ozp;
        @(negedge aclk);
        cfg_index <= REG_ACT_MIN;
        cfg_data <= lo;
        @(negedge aclk);
        cfg_index <= REG_ACT_MAX;
        cfg_data <= hi;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int       sent;
        int       n;
        int       pick;
        logic [7:0] ch;
        dw_item_t it;
        sent = 0;
        while (sent < count) begin
            ch = pool[$urandom_range(POOL_SIZE - 1)];
            pick = $urandom_range(99);
            if (pick < 4) begin
                it = noise_item();
                it.kind = KIND_NONE;
                send_item(it);
                sent++;
            end else if (pick < 8) begin
                random_params(ch);
                sent++;
            end else if (pick < 13) begin
                load_weight(ch, 6'($urandom), 8'($urandom));
                sent++;
            end else if (pick < 16) begin
                random_params(8'($urandom));
                load_weight(8'($urandom), 6'($urandom), 8'($urandom));
                sent += 2;
            end else if (pick < 22 && started[ch]) begin
                send_tap(ch, 6'($urandom), 8'($urandom), 1'($urandom), 1'b0, 1'($urandom));
                sent++;
            end else begin
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                    send_tap(ch, 6'($urandom), 8'($urandom), $urandom_range(9) < 8,
                        i == 0, (i == n - 1) && ($urandom_range(9) != 0));
                sent += n;
            end
        end
    endtask

    initial begin
        no_idle = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IN_ZP;
        cfg_data = 8'd0;
        s_valid = 1'b0;
        s_kind = KIND_NONE;
        s_channel = 8'd0;
        s_tap = 6'd0;
        s_activation = 8'sd0;
        s_in_bounds = 1'b0;
        s_first_tap = 1'b0;
        s_last_tap = 1'b0;
        s_weight = 8'sd0;
        s_bias = 32'sd0;
        s_multiplier = 31'd0;
        s_shift = 6'sd0;
        m_ready = 1'b0;
        foreach (started[i]) started[i] = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        load_params(8'd0, 32'sh7fffffff, 31'h7fffffff, 6'sd31);
        load_params(8'd255, -32'sd2147483648, 31'h40000000, -6'sd32);
        load_weight(8'd0, 6'd0, -8'sd128);
        load_weight(8'd0, 6'd63, 8'sd127);
        load_weight(8'd255, 6'd0, 8'sd127);
        load_weight(8'd255, 6'd63, -8'sd128);
        send_tap(8'd0, 6'd0, -8'sd128, 1'b1, 1'b1, 1'b1);
        send_tap(8'd255, 6'd63, 8'sd127, 1'b1, 1'b1, 1'b0);
        send_tap(8'd255, 6'd0, -8'sd128, 1'b0, 1'b0, 1'b0);
        send_tap(8'd255, 6'd0, 8'sd127, 1'b1, 1'b0, 1'b1);
        send_tap(8'd0, 6'd63, 8'sd127, 1'b0, 1'b1, 1'b1);
        load_params(8'd0, 32'sd0, 31'd0, 6'sd0);
        send_tap(8'd0, 6'd63, 8'sd127, 1'b1, 1'b1, 1'b1);
        load_params(8'd0, 32'sd1000, 31'h7fffffff, 6'sd29);
        send_tap(8'd0, 6'd0, 8'sd127, 1'b1, 1'b1, 1'b1);
        send_tap(8'd0, 6'd0, -8'sd128, 1'b1, 1'b0, 1'b1);
        load_weight(8'($urandom), 6'($urandom), 8'($urandom));
        set_config(-8'sd128, 8'sd127, 8'sd10, -8'sd10);
        send_tap(8'd255, 6'd0, 8'sd127, 1'b1, 1'b1, 1'b1);
        send_tap(8'd0, 6'd63, -8'sd128, 1'b1, 1'b1, 1'b1);

        pool[0] = 8'd0;
        pool[1] = 8'd255;
        for (int i = 2; i < POOL_SIZE; i++) pool[i] = 8'($urandom);
        for (int i = 0; i < POOL_SIZE; i++) begin
            random_params(pool[i]);
            for (int t = 0; t < DEF_MAX_TAPS; t++)
                load_weight(pool[i], 6'(t), 8'($urandom));
        end

        set_config(8'sd0, 8'sd0, INT8_MIN, INT8_MAX);
        random_phase(250);
        set_config(8'sd127, -8'sd128, INT8_MIN, INT8_MAX);
        no_idle = 1'b1;
        random_phase(250);
        no_idle = 1'b0;
        set_config(-8'sd128, 8'sd127, -8'sd40, 8'sd60);
        random_phase(200);
        set_config(8'sd5, -8'sd3, 8'sd20, -8'sd20);
        random_phase(200);
        set_config(8'($urandom), 8'($urandom), -8'sd100, 8'sd100);
        random_phase(250);

        quiesce();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
